FILE: design/tmf_pkg.sv
// tmf_pkg: shared constants, codes, command/status structs and helpers
// for the timestamp match FIFO. No dependencies.
package tmf_pkg;

  localparam int QUEUE_DEPTH  = 64;
  localparam int PAYLOAD_BITS = 64;
  localparam int TALLY_BITS   = 32;

  localparam int IDX_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  localparam int MODE_BITS      = 2;
  localparam int STAMP_BITS     = 64;
  localparam int PAY_PORT_BITS  = 64;
  localparam int STATUS_BITS    = 3;
  localparam int DROP_OUT_BITS  = 7;
  localparam int TALLY_OUT_BITS = 32;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_PUSH  = 2'd0,
    MODE_MATCH = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_PUSHED   = 3'd0,
    ST_MATCHED  = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NO_MATCH = 3'd3,
    ST_OVERFLOW = 3'd4,
    ST_CLEARED  = 3'd5
  } status_t;

  typedef struct packed {
    logic accept;
    logic push;
    logic overflow;
    logic clear;
    logic empty_miss;
    logic drop;
    logic hit;
    logic miss;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  full;
    logic  empty;
    logic  last_entry;
    logic  head_older;
    logic  head_equal;
    logic  out_free;
  } sts_t;

  function automatic logic [TALLY_OUT_BITS-1:0] tally_out(input logic [TALLY_BITS-1:0] t);
    logic [TALLY_OUT_BITS-1:0] r;
    r = '0;
    for (int i = 0; i < TALLY_OUT_BITS; i++) begin
      if (i < TALLY_BITS) r[i] = t[i];
    end
    return r;
  endfunction

  function automatic logic [DROP_OUT_BITS-1:0] drop_out(input logic [CNT_BITS-1:0] c);
    logic [DROP_OUT_BITS-1:0] r;
    r = '0;
    for (int i = 0; i < DROP_OUT_BITS; i++) begin
      if (i < CNT_BITS) r[i] = c[i];
    end
    return r;
  endfunction

  function automatic logic [PAY_PORT_BITS-1:0] pay_out(input logic [PAYLOAD_BITS-1:0] p);
    logic [PAY_PORT_BITS-1:0] r;
    r = '0;
    for (int i = 0; i < PAY_PORT_BITS; i++) begin
      if (i < PAYLOAD_BITS) r[i] = p[i];
    end
    return r;
  endfunction

  function automatic logic [TALLY_BITS-1:0] sat_inc(input logic [TALLY_BITS-1:0] t);
    return (&t) ? t : t + TALLY_BITS'(1);
  endfunction

endpackage

FILE: design/timestamp_match_fifo_core.sv
// timestamp_match_fifo_core: FIFO of timestamp/payload pairs with match by stamp.
// Push, clear, overflow and empty match: accepted in idle, result loaded from the done state.
// Match on a non-empty queue: each head check passes a read and a compare state and
// waits on the registered memory read; older heads are dropped until a hit or a miss.
// One request at a time; the next is taken once the result is in the output register.
// rst (sync, high) empties the queue and clears all tallies; memory is not cleared.
module timestamp_match_fifo_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  req_valid,
  output logic                                  req_ready,
  input  logic [tmf_pkg::MODE_BITS-1:0]         mode,
  input  logic [tmf_pkg::STAMP_BITS-1:0]        stamp,
  input  logic [tmf_pkg::PAY_PORT_BITS-1:0]     payload,
  output logic                                  res_valid,
  input  logic                                  res_ready,
  output logic                                  found,
  output logic [tmf_pkg::PAY_PORT_BITS-1:0]     payload_out,
  output logic [tmf_pkg::STATUS_BITS-1:0]       status,
  output logic [tmf_pkg::DROP_OUT_BITS-1:0]     dropped_now,
  output logic [tmf_pkg::TALLY_OUT_BITS-1:0]    total_pushes,
  output logic [tmf_pkg::TALLY_OUT_BITS-1:0]    total_pops,
  output logic [tmf_pkg::TALLY_OUT_BITS-1:0]    total_drops,
  output logic [tmf_pkg::TALLY_OUT_BITS-1:0]    total_empty_misses,
  output logic [tmf_pkg::TALLY_OUT_BITS-1:0]    total_no_match
);
  import tmf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tmf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tmf_datapath u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .sts                (sts),
    .mode               (mode),
    .stamp              (stamp),
    .payload            (payload),
    .res_valid          (res_valid),
    .res_ready          (res_ready),
    .found              (found),
    .payload_out        (payload_out),
    .status             (status),
    .dropped_now        (dropped_now),
    .total_pushes       (total_pushes),
    .total_pops         (total_pops),
    .total_drops        (total_drops),
    .total_empty_misses (total_empty_misses),
    .total_no_match     (total_no_match)
  );

endmodule

FILE: design/tmf_ctrl.sv
// tmf_ctrl: request sequencer of the timestamp match FIFO.
// Depends on tmf_pkg; drives tmf_datapath through cmd_t, reads sts_t.
module tmf_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  tmf_pkg::sts_t sts,
  output tmf_pkg::cmd_t cmd
);
  import tmf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_CMP  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.accept = 1'b1;
          unique case (sts.mode)
            MODE_PUSH: begin
              if (sts.full) cmd.overflow = 1'b1;
              else          cmd.push     = 1'b1;
              state_next = S_DONE;
            end
            MODE_MATCH: begin
              if (sts.empty) begin
                cmd.empty_miss = 1'b1;
                state_next     = S_DONE;
              end else begin
                state_next = S_READ;
              end
            end
            MODE_CLEAR: begin
              cmd.clear  = 1'b1;
              state_next = S_DONE;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_READ: state_next = S_CMP;
      S_CMP: begin
        if (sts.head_older) begin
          cmd.drop = 1'b1;
          if (sts.last_entry) begin
            cmd.miss   = 1'b1;
            state_next = S_DONE;
          end else begin
            state_next = S_READ;
          end
        end else if (sts.head_equal) begin
          cmd.hit    = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.miss   = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: design/tmf_datapath.sv
// tmf_datapath: entry memory, queue pointers, saturating tallies and the
// result register of the timestamp match FIFO. Depends on tmf_pkg.
module tmf_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  tmf_pkg::cmd_t                         cmd,
  output tmf_pkg::sts_t                         sts,
  input  logic [tmf_pkg::MODE_BITS-1:0]         mode,
  input  logic [tmf_pkg::STAMP_BITS-1:0]        stamp,
  input  logic [tmf_pkg::PAY_PORT_BITS-1:0]     payload,
  output logic                                  res_valid,
  input  logic                                  res_ready,
  output logic                                  found,
  output logic [tmf_pkg::PAY_PORT_BITS-1:0]     payload_out,
  output logic [tmf_pkg::STATUS_BITS-1:0]       status,
  output logic [tmf_pkg::DROP_OUT_BITS-1:0]     dropped_now,
  output logic [tmf_pkg::TALLY_OUT_BITS-1:0]    total_pushes,
  output logic [tmf_pkg::TALLY_OUT_BITS-1:0]    total_pops,
  output logic [tmf_pkg::TALLY_OUT_BITS-1:0]    total_drops,
  output logic [tmf_pkg::TALLY_OUT_BITS-1:0]    total_empty_misses,
  output logic [tmf_pkg::TALLY_OUT_BITS-1:0]    total_no_match
);
  import tmf_pkg::*;

  logic [STAMP_BITS-1:0]   stamp_mem [QUEUE_DEPTH];
  logic [PAYLOAD_BITS-1:0] pay_mem   [QUEUE_DEPTH];
  logic [STAMP_BITS-1:0]   rd_stamp;
  logic [PAYLOAD_BITS-1:0] rd_payload;

  logic [IDX_BITS-1:0]   head, tail;
  logic [CNT_BITS-1:0]   count;
  logic [TALLY_BITS-1:0] push_tally, pop_tally, drop_tally, empty_tally, miss_tally;

  logic [STAMP_BITS-1:0]   req_stamp;
  logic                    res_found;
  logic [PAYLOAD_BITS-1:0] res_payload;
  status_t                 res_status;
  logic [CNT_BITS-1:0]     drop_cnt;
  logic                    pop;

  function automatic logic [IDX_BITS-1:0] next_idx(input logic [IDX_BITS-1:0] i);
    return (i == IDX_BITS'(QUEUE_DEPTH - 1)) ? '0 : i + IDX_BITS'(1);
  endfunction

  assign pop = cmd.drop | cmd.hit;

  assign sts.mode       = mode_t'(mode);
  assign sts.full       = (count == CNT_BITS'(QUEUE_DEPTH));
  assign sts.empty      = (count == '0);
  assign sts.last_entry = (count == CNT_BITS'(1));
  assign sts.head_older = (rd_stamp < req_stamp);
  assign sts.head_equal = (rd_stamp == req_stamp);
  assign sts.out_free   = !res_valid || res_ready;

  // entry memory, registered read at head
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stamp_mem[tail] <= stamp;
      pay_mem[tail]   <= payload[PAYLOAD_BITS-1:0];
    end
    rd_stamp   <= stamp_mem[head];
    rd_payload <= pay_mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head        <= '0;
      tail        <= '0;
      count       <= '0;
      push_tally  <= '0;
      pop_tally   <= '0;
      drop_tally  <= '0;
      empty_tally <= '0;
      miss_tally  <= '0;
    end else begin
      if (cmd.clear) begin
        head  <= '0;
        tail  <= '0;
        count <= '0;
      end else if (cmd.push) begin
        tail       <= next_idx(tail);
        count      <= count + CNT_BITS'(1);
        push_tally <= sat_inc(push_tally);
      end else if (pop) begin
        head      <= next_idx(head);
        count     <= count - CNT_BITS'(1);
        pop_tally <= sat_inc(pop_tally);
      end
      if (cmd.drop)       drop_tally  <= sat_inc(drop_tally);
      if (cmd.empty_miss) empty_tally <= sat_inc(empty_tally);
      if (cmd.miss)       miss_tally  <= sat_inc(miss_tally);
    end
  end

  // per-request result
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_stamp   <= stamp;
      res_found   <= 1'b0;
      res_payload <= '0;
      drop_cnt    <= '0;
    end
    if (cmd.drop) drop_cnt <= drop_cnt + CNT_BITS'(1);
    if (cmd.hit) begin
      res_found   <= 1'b1;
      res_payload <= rd_payload;
    end
    if (cmd.push)       res_status <= ST_PUSHED;
    if (cmd.overflow)   res_status <= ST_OVERFLOW;
    if (cmd.clear)      res_status <= ST_CLEARED;
    if (cmd.empty_miss) res_status <= ST_EMPTY;
    if (cmd.hit)        res_status <= ST_MATCHED;
    if (cmd.miss)       res_status <= ST_NO_MATCH;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load_out) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      found              <= res_found;
      payload_out        <= pay_out(res_payload);
      status             <= res_status;
      dropped_now        <= drop_out(drop_cnt);
      total_pushes       <= tally_out(push_tally);
      total_pops         <= tally_out(pop_tally);
      total_drops        <= tally_out(drop_tally);
      total_empty_misses <= tally_out(empty_tally);
      total_no_match     <= tally_out(miss_tally);
    end
  end

endmodule

FILE: design/tmf_checker.sv
// tmf_checker: port-level assertions for timestamp_match_fifo_core, bound below.
// Depends on tmf_pkg for the status codes.
module tmf_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  res_valid,
  input logic                                  res_ready,
  input logic                                  found,
  input logic [tmf_pkg::PAY_PORT_BITS-1:0]     payload_out,
  input logic [tmf_pkg::STATUS_BITS-1:0]       status,
  input logic [tmf_pkg::DROP_OUT_BITS-1:0]     dropped_now,
  input logic [tmf_pkg::TALLY_OUT_BITS-1:0]    total_empty_misses
);
  import tmf_pkg::*;

  a_reset_idle: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(status) && $stable(payload_out))
    else $error("stalled result changed");

  a_found: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (found == (status == ST_MATCHED)) &&
                  (found || payload_out == '0))
    else $error("found/payload inconsistent with status");

  a_drops: assert property (@(posedge clk) disable iff (rst)
    res_valid && status != ST_MATCHED && status != ST_NO_MATCH |-> dropped_now == '0)
    else $error("drops reported outside a match");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == ST_EMPTY |-> total_empty_misses != '0)
    else $error("empty miss not counted");

endmodule

bind timestamp_match_fifo_core tmf_checker u_tmf_checker (.*);

FILE: bench/match_fifo_checker.sv
// match_fifo_checker: watches the request and result channels of the timestamp
// match FIFO, predicts every result and compares it field by field.
// Depends on tmf_pkg for widths, mode and status codes.
`timescale 1ns / 1ps

module match_fifo_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  input  logic                                req_ready,
  input  logic [tmf_pkg::MODE_BITS-1:0]       mode,
  input  logic [tmf_pkg::STAMP_BITS-1:0]      stamp,
  input  logic [tmf_pkg::PAY_PORT_BITS-1:0]   payload,
  input  logic                                res_valid,
  input  logic                                res_ready,
  input  logic                                found,
  input  logic [tmf_pkg::PAY_PORT_BITS-1:0]   payload_out,
  input  logic [tmf_pkg::STATUS_BITS-1:0]     status,
  input  logic [tmf_pkg::DROP_OUT_BITS-1:0]   dropped_now,
  input  logic [tmf_pkg::TALLY_OUT_BITS-1:0]  total_pushes,
  input  logic [tmf_pkg::TALLY_OUT_BITS-1:0]  total_pops,
  input  logic [tmf_pkg::TALLY_OUT_BITS-1:0]  total_drops,
  input  logic [tmf_pkg::TALLY_OUT_BITS-1:0]  total_empty_misses,
  input  logic [tmf_pkg::TALLY_OUT_BITS-1:0]  total_no_match,
  output int                                  mismatches,
  output int                                  outstanding
);
  import tmf_pkg::*;

  typedef struct packed {
    logic                      found;
    logic [PAY_PORT_BITS-1:0]  pay;
    logic [STATUS_BITS-1:0]    status;
    logic [DROP_OUT_BITS-1:0]  dropped;
    logic [TALLY_OUT_BITS-1:0] pushes;
    logic [TALLY_OUT_BITS-1:0] pops;
    logic [TALLY_OUT_BITS-1:0] drops;
    logic [TALLY_OUT_BITS-1:0] empties;
    logic [TALLY_OUT_BITS-1:0] misses;
  } match_result_t;

  match_result_t pending_results[$];

  logic [STAMP_BITS-1:0]   stamp_mem [QUEUE_DEPTH];
  logic [PAYLOAD_BITS-1:0] meta_mem  [QUEUE_DEPTH];
  int unsigned             head_pos;
  int unsigned             tail_pos;
  int unsigned             held;
  logic [TALLY_BITS-1:0]   push_n, pop_n, drop_n, empty_n, miss_n;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic logic [TALLY_BITS-1:0] bump(input logic [TALLY_BITS-1:0] t);
    return (t == '1) ? t : t + 1'b1;
  endfunction

  task automatic retire_head();
    head_pos = (head_pos + 1) % QUEUE_DEPTH;
    held     = held - 1;
    pop_n    = bump(pop_n);
  endtask

  task automatic apply_request(input logic [MODE_BITS-1:0] m,
                               input logic [STAMP_BITS-1:0] s,
                               input logic [PAY_PORT_BITS-1:0] p);
    match_result_t r;
    r = '0;
    case (m)
      MODE_PUSH: begin
        if (held == QUEUE_DEPTH) begin
          r.status = ST_OVERFLOW;
        end else begin
          stamp_mem[tail_pos] = s;
          meta_mem[tail_pos]  = PAYLOAD_BITS'(p);
          tail_pos = (tail_pos + 1) % QUEUE_DEPTH;
          held     = held + 1;
          push_n   = bump(push_n);
          r.status = ST_PUSHED;
        end
      end
      MODE_MATCH: begin
        if (held == 0) begin
          empty_n  = bump(empty_n);
          r.status = ST_EMPTY;
        end else begin
          while (held != 0 && stamp_mem[head_pos] < s) begin
            retire_head();
            drop_n    = bump(drop_n);
            r.dropped = r.dropped + 1'b1;
          end
          if (held != 0 && stamp_mem[head_pos] == s) begin
            r.found  = 1'b1;
            r.pay    = PAY_PORT_BITS'(meta_mem[head_pos]);
            r.status = ST_MATCHED;
            retire_head();
          end else begin
            miss_n   = bump(miss_n);
            r.status = ST_NO_MATCH;
          end
        end
      end
      MODE_CLEAR: begin
        head_pos = 0;
        tail_pos = 0;
        held     = 0;
        r.status = ST_CLEARED;
      end
      default: return;
    endcase
    r.pushes  = TALLY_OUT_BITS'(push_n);
    r.pops    = TALLY_OUT_BITS'(pop_n);
    r.drops   = TALLY_OUT_BITS'(drop_n);
    r.empties = TALLY_OUT_BITS'(empty_n);
    r.misses  = TALLY_OUT_BITS'(miss_n);
    pending_results = {pending_results, r};
  endtask

  always @(posedge clk) begin
    match_result_t got, want;
    if (rst) begin
      pending_results.delete();
      head_pos = 0;
      tail_pos = 0;
      held     = 0;
      push_n   = '0;
      pop_n    = '0;
      drop_n   = '0;
      empty_n  = '0;
      miss_n   = '0;
    end else begin
      if (res_valid && res_ready) begin
        got = '{found, payload_out, status, dropped_now, total_pushes, total_pops,
                total_drops, total_empty_misses, total_no_match};
        if (pending_results.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("%0t: result with no request pending: status %0d", $realtime, status);
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          if (got !== want) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  found   exp %b act %b", want.found, got.found);
              $display("  payload exp %h act %h", want.pay, got.pay);
              $display("  status  exp %0d act %0d  dropped exp %0d act %0d",
                       want.status, got.status, want.dropped, got.dropped);
              $display("  tallies exp %0d %0d %0d %0d %0d act %0d %0d %0d %0d %0d",
                       want.pushes, want.pops, want.drops, want.empties, want.misses,
                       got.pushes, got.pops, got.drops, got.empties, got.misses);
            end
          end
        end
      end
      if (req_valid && req_ready)
        apply_request(mode, stamp, payload);
    end
    outstanding <= pending_results.size();
  end

endmodule

FILE: bench/timestamp_match_fifo_core_test.sv
// timestamp_match_fifo_core_test: drives directed and random requests into the
// timestamp match FIFO with random idling and back-pressure; match_fifo_checker judges.
// Depends on tmf_pkg, timestamp_match_fifo_core and match_fifo_checker.
`timescale 1ns / 1ps

module timestamp_match_fifo_core_test;
  import tmf_pkg::*;

  localparam int ITEMS       = 1150;
  localparam int QUIET_TAIL  = 150;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 4000;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      req_valid = 1'b0;
  logic                      req_ready;
  logic [MODE_BITS-1:0]      mode = MODE_NONE;
  logic [STAMP_BITS-1:0]     stamp = '0;
  logic [PAY_PORT_BITS-1:0]  payload = '0;
  logic                      res_valid;
  logic                      res_ready = 1'b0;
  logic                      found;
  logic [PAY_PORT_BITS-1:0]  payload_out;
  logic [STATUS_BITS-1:0]    status;
  logic [DROP_OUT_BITS-1:0]  dropped_now;
  logic [TALLY_OUT_BITS-1:0] total_pushes, total_pops, total_drops;
  logic [TALLY_OUT_BITS-1:0] total_empty_misses, total_no_match;

  int mismatches;
  int outstanding;
  int sent = 0;
  int stall_cycles = 0;
  bit quiet = 1'b0;
  bit hold_off = 1'b0;

  logic [STAMP_BITS-1:0] next_stamp;
  logic [STAMP_BITS-1:0] live[$];

  timestamp_match_fifo_core uut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready),
    .mode(mode), .stamp(stamp), .payload(payload),
    .res_valid(res_valid), .res_ready(res_ready),
    .found(found), .payload_out(payload_out), .status(status),
    .dropped_now(dropped_now), .total_pushes(total_pushes), .total_pops(total_pops),
    .total_drops(total_drops), .total_empty_misses(total_empty_misses),
    .total_no_match(total_no_match)
  );

  match_fifo_checker checker_i (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready),
    .mode(mode), .stamp(stamp), .payload(payload),
    .res_valid(res_valid), .res_ready(res_ready),
    .found(found), .payload_out(payload_out), .status(status),
    .dropped_now(dropped_now), .total_pushes(total_pushes), .total_pops(total_pops),
    .total_drops(total_drops), .total_empty_misses(total_empty_misses),
    .total_no_match(total_no_match),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (res_valid && res_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("timestamp_match_fifo_core_test NOT OK");
        $finish;
      end
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_off) begin
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end else if (quiet || $urandom_range(0, 3) != 0) begin
        res_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        res_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic offer(input mode_t m, input logic [STAMP_BITS-1:0] s,
                       input logic [PAY_PORT_BITS-1:0] p);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    req_valid <= 1'b1;
    mode      <= m;
    stamp     <= s;
    payload   <= p;
    @(negedge clk);
    while (!req_ready) @(negedge clk);
    @(posedge clk);
    if (m != MODE_NONE) sent++;
  endtask

  task automatic push_frame();
    offer(MODE_PUSH, next_stamp, rand64());
    if (live.size() < QUEUE_DEPTH) live = {live, next_stamp};
    next_stamp = next_stamp + $urandom_range(1, 4);
  endtask

  task automatic match_frame();
    int pick;
    logic [STAMP_BITS-1:0] target;
    if (live.size() == 0) begin
      offer(MODE_MATCH, next_stamp, rand64());
      return;
    end
    pick   = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(0, live.size() - 1);
    target = live[pick];
    case ($urandom_range(0, 9))
      0: target = target + 1;
      1: target = next_stamp + $urandom_range(0, 20);
      default: ;
    endcase
    offer(MODE_MATCH, target, rand64());
    while (live.size() != 0 && live[0] <= target) live.delete(0);
  endtask

  task automatic clear_queue();
    offer(MODE_CLEAR, rand64(), rand64());
    live.delete();
    next_stamp = rand64() >> 1;
  endtask

  initial begin
    int roll;
    next_stamp = rand64() >> 1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed
    offer(MODE_MATCH, 64'd5, rand64());
    offer(MODE_PUSH, '0, '0);
    offer(MODE_PUSH, '1, '1);
    offer(MODE_MATCH, '0, rand64());
    offer(MODE_MATCH, '1, rand64());
    offer(MODE_PUSH, 64'd100, rand64());
    offer(MODE_PUSH, 64'd200, rand64());
    offer(MODE_PUSH, 64'd300, rand64());
    offer(MODE_MATCH, 64'd200, rand64());
    offer(MODE_MATCH, 64'd250, rand64());
    offer(MODE_MATCH, 64'd400, rand64());
    offer(MODE_PUSH, 64'd10, rand64());
    offer(MODE_PUSH, 64'd20, rand64());
    offer(MODE_CLEAR, '1, '1);
    offer(MODE_MATCH, 64'd10, rand64());
    offer(MODE_NONE, rand64(), rand64());
    offer(MODE_PUSH, 64'd7, 64'h8000_0000_0000_0001);
    offer(MODE_MATCH, 64'd7, rand64());
    offer(MODE_PUSH, 64'h8000_0000_0000_0000, rand64());
    offer(MODE_MATCH, 64'h7fff_ffff_ffff_ffff, rand64());
    offer(MODE_MATCH, 64'h8000_0000_0000_0000, rand64());

    // back-pressure: start a long result hold-off, fill past full, then drop everything
    clear_queue();
    hold_off = 1'b1;
    repeat (QUEUE_DEPTH + 2) push_frame();
    offer(MODE_MATCH, next_stamp, rand64());
    live.delete();
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);

    // random
    while (sent < ITEMS) begin
      if (sent >= ITEMS - QUIET_TAIL) quiet = 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 72) begin
        repeat ($urandom_range(1, 12)) begin
          if ($urandom_range(0, 99) < 55) push_frame();
          else match_frame();
        end
      end else if (roll < 75) begin
        while (live.size() < QUEUE_DEPTH) push_frame();
        repeat ($urandom_range(0, 2)) push_frame();
      end else if (roll < 82) begin
        clear_queue();
      end else if (roll < 91) begin
        offer(mode_t'(2'($urandom_range(0, 3))), rand64(), rand64());
      end else begin
        offer(MODE_MATCH, rand64(), rand64());
      end
    end

    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0)
      $display("timestamp_match_fifo_core_test OK");
    else
      $display("timestamp_match_fifo_core_test NOT OK");
    $finish;
  end

endmodule
